>>> design/drl_pkg.sv
package drl_pkg;

  localparam int unsigned FrameWidth = 21;
  localparam int unsigned IndexWidth = 20;
  localparam int unsigned CodeWidth = 8;
  localparam int unsigned RunWidth = 8;
  localparam int unsigned LowWidth = 6;
  localparam int unsigned SkipWidth = 15;
  localparam int unsigned MaxWidth = 25;

  localparam int unsigned MAX_FRAME_PIXELS_DEFAULT = 1048576;
  localparam logic [FrameWidth-1:0] FRAME_PIXELS_RESET = 21'd76800;

  localparam logic [CodeWidth-1:0] SHORT_SKIP_BASE = 8'd128;
  localparam logic [CodeWidth-1:0] LONG_SKIP_BASE = 8'd192;
  localparam logic [CodeWidth-1:0] SHORT_SKIP_BIAS = 8'd125;
  localparam logic [SkipWidth-1:0] LONG_SKIP_BIAS = 15'd3;

  typedef enum logic [1:0] {
    CLS_LITERAL,
    CLS_SHORT_SKIP,
    CLS_LONG_SKIP
  } code_class_t;

  typedef struct packed {
    logic                 start;
    logic [CodeWidth-1:0] code;
    code_class_t          cls;
    logic [RunWidth-1:0]  run;
  } item_t;

  typedef struct packed {
    logic                  write_enable;
    logic [IndexWidth-1:0] pixel_index;
    logic [CodeWidth-1:0]  pixel_value;
    logic                  frame_done;
  } result_t;

endpackage

>>> design/drl_front.sv
module drl_front (
  input  logic                          frame_start,
  input  logic [drl_pkg::CodeWidth-1:0] code_byte,
  output drl_pkg::item_t                item
);

  // Classify the byte as a control byte; the back end decides whether it is one.
  always_comb begin
    item.start = frame_start;
    item.code = code_byte;
    if (code_byte >= drl_pkg::LONG_SKIP_BASE) begin
      item.cls = drl_pkg::CLS_LONG_SKIP;
      item.run = '0;
    end else if (code_byte >= drl_pkg::SHORT_SKIP_BASE) begin
      item.cls = drl_pkg::CLS_SHORT_SKIP;
      item.run = code_byte - drl_pkg::SHORT_SKIP_BIAS;
    end else begin
      item.cls = drl_pkg::CLS_LITERAL;
      item.run = code_byte + 8'd1;
    end
  end

endmodule

>>> design/drl_queue.sv
module drl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  drl_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output drl_pkg::item_t head_item
);

  drl_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/drl_back.sv
module drl_back #(
  parameter int unsigned MAX_FRAME_PIXELS = drl_pkg::MAX_FRAME_PIXELS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [drl_pkg::FrameWidth-1:0] frame_pixels,
  input  logic                           head_valid,
  input  drl_pkg::item_t                 head_item,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output drl_pkg::result_t               result
);

  localparam logic [drl_pkg::MaxWidth-1:0] MaxPixels = drl_pkg::MaxWidth'(MAX_FRAME_PIXELS);

  typedef enum logic [1:0] {
    MODE_CONTROL,
    MODE_SKIP_HIGH,
    MODE_LITERAL,
    MODE_DONE
  } mode_t;

  mode_t                         mode;
  logic [drl_pkg::FrameWidth-1:0] position;
  logic [drl_pkg::RunWidth-1:0]   literal_left;
  logic [drl_pkg::LowWidth-1:0]   skip_low_part;

  mode_t                          mode_next;
  logic [drl_pkg::FrameWidth-1:0] position_next;
  logic [drl_pkg::RunWidth-1:0]   literal_left_next;
  logic [drl_pkg::LowWidth-1:0]   skip_low_part_next;
  logic                           out_valid_next;
  drl_pkg::result_t               result_next;

  mode_t                          cur_mode;
  logic [drl_pkg::FrameWidth-1:0] cur_position;
  logic [drl_pkg::RunWidth-1:0]   cur_left;
  logic [drl_pkg::LowWidth-1:0]   cur_low;
  logic [drl_pkg::FrameWidth-1:0] limit;
  logic [drl_pkg::SkipWidth-1:0]  skip_count;
  logic [drl_pkg::FrameWidth:0]   skip_sum;
  logic [drl_pkg::FrameWidth:0]   step_sum;
  logic [drl_pkg::RunWidth-1:0]   left_dec;
  logic                           last_pixel;

  assign pop = head_valid && (!out_valid || !out_stall);

  // Clamp the frame size into 1..MAX_FRAME_PIXELS.
  always_comb begin
    if (frame_pixels == '0) begin
      limit = drl_pkg::FrameWidth'(1);
    end else if ({4'b0, frame_pixels} > MaxPixels) begin
      limit = MaxPixels[drl_pkg::FrameWidth-1:0];
    end else begin
      limit = frame_pixels;
    end
  end

  // A frame start clears the decode state before the byte is taken.
  always_comb begin
    if (head_item.start) begin
      cur_mode = MODE_CONTROL;
      cur_position = '0;
      cur_left = '0;
      cur_low = '0;
    end else begin
      cur_mode = mode;
      cur_position = position;
      cur_left = literal_left;
      cur_low = skip_low_part;
    end
  end

  always_comb begin
    if (cur_mode == MODE_SKIP_HIGH) begin
      skip_count = {1'b0, head_item.code, 6'b0} + {9'b0, cur_low} + drl_pkg::LONG_SKIP_BIAS;
    end else begin
      skip_count = {7'b0, head_item.run};
    end
    skip_sum = {1'b0, cur_position} + {7'b0, skip_count};
    step_sum = {1'b0, cur_position} + 22'd1;
    left_dec = cur_left - 8'd1;
    last_pixel = (step_sum >= {1'b0, limit});
  end

  // Next decode state; the output register drains when the receiver takes it.
  always_comb begin
    mode_next = mode;
    position_next = position;
    literal_left_next = literal_left;
    skip_low_part_next = skip_low_part;
    out_valid_next = out_valid && out_stall;
    result_next = result;
    if (pop) begin
      mode_next = cur_mode;
      position_next = cur_position;
      literal_left_next = cur_left;
      skip_low_part_next = cur_low;
      case (cur_mode)
        MODE_CONTROL, MODE_SKIP_HIGH: begin
          if (cur_mode == MODE_CONTROL && head_item.cls == drl_pkg::CLS_LONG_SKIP) begin
            skip_low_part_next = head_item.code[drl_pkg::LowWidth-1:0];
            mode_next = MODE_SKIP_HIGH;
          end else if (cur_mode == MODE_CONTROL && head_item.cls == drl_pkg::CLS_LITERAL) begin
            literal_left_next = head_item.run;
            mode_next = MODE_LITERAL;
          end else if (skip_sum >= {1'b0, limit}) begin
            // skip runs off the end: stop at the frame size, send a notice
            position_next = limit;
            mode_next = MODE_DONE;
            out_valid_next = 1'b1;
            result_next = '{write_enable: 1'b0, pixel_index: '0, pixel_value: '0,
                            frame_done: 1'b1};
          end else begin
            position_next = skip_sum[drl_pkg::FrameWidth-1:0];
            mode_next = MODE_CONTROL;
          end
        end
        MODE_LITERAL: begin
          position_next = step_sum[drl_pkg::FrameWidth-1:0];
          literal_left_next = left_dec;
          if (last_pixel) begin
            mode_next = MODE_DONE;
          end else if (left_dec == '0) begin
            mode_next = MODE_CONTROL;
          end
          out_valid_next = 1'b1;
          result_next = '{write_enable: 1'b1,
                          pixel_index: cur_position[drl_pkg::IndexWidth-1:0],
                          pixel_value: head_item.code,
                          frame_done: last_pixel};
        end
        default: begin
          mode_next = MODE_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_CONTROL;
      position <= '0;
      literal_left <= '0;
      skip_low_part <= '0;
      out_valid <= 1'b0;
      result <= '0;
    end else begin
      mode <= mode_next;
      position <= position_next;
      literal_left <= literal_left_next;
      skip_low_part <= skip_low_part_next;
      out_valid <= out_valid_next;
      result <= result_next;
    end
  end

endmodule

>>> design/delta_rle_frame_decoder.sv
// A coded byte is written into the queue when it is accepted; its result item then moves
//   through the decode unit into the output register once the output side can take it.
// Throughput: one coded byte per cycle unless the output stalls, set by the back-end position update.
// Reset (rst, synchronous): queue empty, output invalid, decoder expects a control byte
//   at position 0, frame_pixels returns to 76800.
module delta_rle_frame_decoder #(
  parameter int unsigned MAX_FRAME_PIXELS = drl_pkg::MAX_FRAME_PIXELS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // frame size register
  input  logic                            cfg_write_enable,
  input  logic [drl_pkg::FrameWidth-1:0]  cfg_write_data,
  // coded byte stream
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            frame_start,
  input  logic [drl_pkg::CodeWidth-1:0]   code_byte,
  // pixel writes and completion notices
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            write_enable,
  output logic [drl_pkg::IndexWidth-1:0]  pixel_index,
  output logic [drl_pkg::CodeWidth-1:0]   pixel_value,
  output logic                            frame_done
);

  logic [drl_pkg::FrameWidth-1:0] frame_pixels;

  drl_pkg::item_t   front_item;
  drl_pkg::item_t   head_item;
  drl_pkg::result_t result;
  logic             queue_full;
  logic             head_valid;
  logic             pop;
  logic             push;

  // Frame size; the user must write it only while the decoder is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels <= drl_pkg::FRAME_PIXELS_RESET;
    end else if (cfg_write_enable) begin
      frame_pixels <= cfg_write_data;
    end
  end

  // Front end: take a byte whenever the queue has room, independent of the output side.
  assign in_stall = queue_full;
  assign push = in_valid && !queue_full;

  drl_front u_front (
    .frame_start (frame_start),
    .code_byte   (code_byte),
    .item        (front_item)
  );

  // Two entries decouple the input handshake from output back-pressure; in steady
  // flow the queue holds at most one item, so input never stalls unless the output does.
  drl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (front_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Back end: mode, position and run counters; one queued byte per cycle while
  // the output register is free or draining.
  drl_back #(
    .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .frame_pixels (frame_pixels),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result       (result)
  );

  assign write_enable = result.write_enable;
  assign pixel_index = result.pixel_index;
  assign pixel_value = result.pixel_value;
  assign frame_done = result.frame_done;

endmodule
